FILE: rtl/bic_pkg.sv
// Shared types and constants of the binary image centroid block.
`default_nettype none

package bic_pkg;

   // Fixed field widths
   localparam int PIX_W  = 8;
   localparam int DIM_W  = 13;
   localparam int OUT_W  = 12;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_TEST_MODE = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_WIDTH     = 2'd2;
   localparam logic [1:0] REG_HEIGHT    = 2'd3;

   // Pixel test modes
   localparam logic MODE_NONZERO   = 1'b0;
   localparam logic MODE_THRESHOLD = 1'b1;

   // Register reset values
   localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd1;
   localparam logic [DIM_W-1:0] WIDTH_RESET     = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = 13'd480;

   // Configuration as seen by the pixel front end
   typedef struct packed {
      logic             test_mode;
      logic [PIX_W-1:0] pixel_threshold;
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
   } bic_cfg_type;

   // Frame queue status
   typedef struct packed {
      logic valid;
      logic full;
   } bic_qstat_type;

endpackage

`default_nettype wire

FILE: rtl/bic_queue.sv
// Two-entry queue of finished frame records between front and back end.
`default_nettype none

module bic_queue
   import bic_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head_data,
   output bic_qstat_type         status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed record
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.valid = (fill_ff != 2'd0);
   assign status.full  = (fill_ff == 2'd2);

endmodule

`default_nettype wire

FILE: rtl/bic_front.sv
// Pixel front end: raster position, set test and first-moment accumulation.
`default_nettype none

module bic_front
   import bic_pkg::*;
#(
   parameter int MAX_DIMENSION = 4096,
   localparam int CW      = $clog2(MAX_DIMENSION),
   localparam int SW      = $clog2(MAX_DIMENSION + 1),
   localparam int COUNT_W = 2 * CW + 1,
   localparam int SUM_W   = 3 * CW,
   localparam int REC_W   = 2 * SUM_W + COUNT_W + 2 * OUT_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bic_cfg_type      cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [PIX_W-1:0] req_pixel_value,
   input  wire bic_qstat_type    qstat,
   output logic                  push,
   output logic      [REC_W-1:0] push_data
);

   logic [CW-1:0]      col_ff, col_in;
   logic [CW-1:0]      row_ff, row_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   col_sum_ff, col_sum_in;
   logic [SUM_W-1:0]   row_sum_ff, row_sum_in;

   logic [SW-1:0]      width_eff, height_eff;
   logic [SW-1:0]      col_next, row_next;
   logic               last_col, last_row, frame_last;
   logic               pixel_set, accept;
   logic [COUNT_W-1:0] count_upd;
   logic [SUM_W-1:0]   col_sum_upd, row_sum_upd;
   logic [SW+OUT_W-1:0] half_w_wide, half_h_wide;

   // Clamp a size register to 1..MAX_DIMENSION
   function automatic logic [SW-1:0] clamp_size(input logic [DIM_W-1:0] size);
      logic [31:0] size32;
      size32 = 32'(size);
      if (size32 == 32'd0) begin
         return SW'(1);
      end
      if (size32 > 32'(MAX_DIMENSION)) begin
         return SW'(MAX_DIMENSION);
      end
      return SW'(size32);
   endfunction

   assign width_eff  = clamp_size(cfg.frame_width);
   assign height_eff = clamp_size(cfg.frame_height);

   // Row and frame end: counter plus one reaches or passes the size
   assign col_next   = SW'(col_ff) + SW'(1);
   assign row_next   = SW'(row_ff) + SW'(1);
   assign last_col   = (col_next >= width_eff);
   assign last_row   = (row_next >= height_eff);
   assign frame_last = last_col && last_row;

   // Hold the request only when the frame result has no queue slot
   assign req_ready = !(frame_last && qstat.full);
   assign accept    = req_valid && req_ready;
   assign push      = accept && frame_last;

   // Judge the pixel
   always_comb begin
      unique case (cfg.test_mode)
         MODE_THRESHOLD: pixel_set = (req_pixel_value >= cfg.pixel_threshold);
         default:        pixel_set = (req_pixel_value != '0);
      endcase
   end

   // Accumulate moments including this pixel
   always_comb begin
      count_upd   = count_ff;
      col_sum_upd = col_sum_ff;
      row_sum_upd = row_sum_ff;
      if (pixel_set) begin
         count_upd   = count_ff + COUNT_W'(1);
         col_sum_upd = col_sum_ff + SUM_W'(col_ff);
         row_sum_upd = row_sum_ff + SUM_W'(row_ff);
      end
   end

   // Advance raster position; clear at frame end
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      count_in   = count_ff;
      col_sum_in = col_sum_ff;
      row_sum_in = row_sum_ff;
      if (accept) begin
         count_in   = count_upd;
         col_sum_in = col_sum_upd;
         row_sum_in = row_sum_upd;
         priority if (!last_col) begin
            col_in = col_next[CW-1:0];
         end else if (!last_row) begin
            col_in = '0;
            row_in = row_next[CW-1:0];
         end else begin
            col_in     = '0;
            row_in     = '0;
            count_in   = '0;
            col_sum_in = '0;
            row_sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         count_ff   <= '0;
         col_sum_ff <= '0;
         row_sum_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         count_ff   <= count_in;
         col_sum_ff <= col_sum_in;
         row_sum_ff <= row_sum_in;
      end
   end

   // Frame centre for an empty frame
   assign half_w_wide = (SW + OUT_W)'(width_eff >> 1);
   assign half_h_wide = (SW + OUT_W)'(height_eff >> 1);

   assign push_data = {col_sum_upd, row_sum_upd, count_upd,
                       half_w_wide[OUT_W-1:0], half_h_wide[OUT_W-1:0]};

endmodule

`default_nettype wire

FILE: rtl/bic_back.sv
// Back end: two restoring dividers for the centroid and the response register.
`default_nettype none

module bic_back
   import bic_pkg::*;
#(
   parameter int MAX_DIMENSION = 4096,
   localparam int CW      = $clog2(MAX_DIMENSION),
   localparam int COUNT_W = 2 * CW + 1,
   localparam int SUM_W   = 3 * CW,
   localparam int REC_W   = 2 * SUM_W + COUNT_W + 2 * OUT_W,
   localparam int STEP_W  = $clog2(SUM_W + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bic_qstat_type    qstat,
   input  wire logic [REC_W-1:0] head_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [OUT_W-1:0] rsp_centroid_x,
   output logic      [OUT_W-1:0] rsp_centroid_y,
   output logic                  rsp_frame_empty
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SUM_W-1:0]   quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [COUNT_W-1:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [OUT_W-1:0]   half_w_ff, half_w_in, half_h_ff, half_h_in;
   logic               empty_ff, empty_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic [SUM_W-1:0]   rec_col_sum, rec_row_sum;
   logic [COUNT_W-1:0] rec_count;
   logic [OUT_W-1:0]   rec_half_w, rec_half_h;
   logic [COUNT_W:0]   shift_x, shift_y, div_wide;
   logic               ge_x, ge_y, load_rsp;
   logic [SUM_W+OUT_W-1:0] quo_x_wide, quo_y_wide;

   assign {rec_col_sum, rec_row_sum, rec_count, rec_half_w, rec_half_h} = head_data;

   // One restoring step of each divider
   assign div_wide = {1'b0, div_ff};
   assign shift_x  = {rem_x_ff, quo_x_ff[SUM_W-1]};
   assign shift_y  = {rem_y_ff, quo_y_ff[SUM_W-1]};
   assign ge_x     = (shift_x >= div_wide);
   assign ge_y     = (shift_y >= div_wide);

   assign quo_x_wide = (SUM_W + OUT_W)'(quo_x_ff);
   assign quo_y_wide = (SUM_W + OUT_W)'(quo_y_ff);

   assign pop      = (state_ff == ST_IDLE) && qstat.valid;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequence: take a record, divide, hand over to the response register
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      quo_x_in  = quo_x_ff;
      quo_y_in  = quo_y_ff;
      rem_x_in  = rem_x_ff;
      rem_y_in  = rem_y_ff;
      div_in    = div_ff;
      half_w_in = half_w_ff;
      half_h_in = half_h_ff;
      empty_in  = empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (qstat.valid) begin
               quo_x_in  = rec_col_sum;
               quo_y_in  = rec_row_sum;
               rem_x_in  = '0;
               rem_y_in  = '0;
               div_in    = rec_count;
               half_w_in = rec_half_w;
               half_h_in = rec_half_h;
               step_in   = '0;
               empty_in  = (rec_count == '0);
               state_in  = (rec_count == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            quo_x_in = {quo_x_ff[SUM_W-2:0], ge_x};
            quo_y_in = {quo_y_ff[SUM_W-2:0], ge_y};
            rem_x_in = ge_x ? COUNT_W'(shift_x - div_wide) : shift_x[COUNT_W-1:0];
            rem_y_in = ge_y ? COUNT_W'(shift_y - div_wide) : shift_y[COUNT_W-1:0];
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response until taken; load the next when the slot frees
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_empty_in = rsp_empty_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_empty_in = empty_ff;
         rsp_x_in     = empty_ff ? half_w_ff : quo_x_wide[OUT_W-1:0];
         rsp_y_in     = empty_ff ? half_h_ff : quo_y_wide[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      quo_x_ff     <= quo_x_in;
      quo_y_ff     <= quo_y_in;
      rem_x_ff     <= rem_x_in;
      rem_y_ff     <= rem_y_in;
      div_ff       <= div_in;
      half_w_ff    <= half_w_in;
      half_h_ff    <= half_h_in;
      empty_ff     <= empty_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_centroid_x  = rsp_x_ff;
   assign rsp_centroid_y  = rsp_y_ff;
   assign rsp_frame_empty = rsp_empty_ff;

endmodule

`default_nettype wire

FILE: rtl/binary_image_centroid.sv
// Top level of the binary image centroid block with its register port.
//
// Usage: gray pixels enter in raster order on the request channel (req_valid,
// req_ready, req_pixel_value), one per cycle. The block tracks column and row
// from frame_width and frame_height, counts set pixels and sums their column
// and row. After the last pixel of a frame one response (rsp_centroid_x,
// rsp_centroid_y, rsp_frame_empty) carries the truncated centroid, or the
// frame centre with rsp_frame_empty high when no pixel was set.
// Throughput: one pixel per cycle. The front end stalls only on the last pixel
// of a frame while two finished frames wait in the frame queue.
// From the last pixel of a frame, its record passes the frame queue, the back
// end loads it into the two restoring dividers, which produce one quotient bit
// per cycle, and the result goes to the response register; an empty frame skips
// the dividers. The back end takes a new frame only once the last one has gone
// to the response register.
// Reset (synchronous) clears the raster position, the accumulators, the queue
// and the valid flag of the response register, and restores the register defaults.
// A stalled response holds its value; the back end finishes the next frame and
// waits, and the queue absorbs further frames before the request side stalls.
// Registers are written over the APB-style port at byte address 4 * index.
`default_nettype none

module binary_image_centroid
   import bic_pkg::*;
#(
   parameter int MAX_DIMENSION = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [PIX_W-1:0]  req_pixel_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [OUT_W-1:0]  rsp_centroid_x,
   output logic      [OUT_W-1:0]  rsp_centroid_y,
   output logic                   rsp_frame_empty,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   localparam int CW      = $clog2(MAX_DIMENSION);
   localparam int COUNT_W = 2 * CW + 1;
   localparam int SUM_W   = 3 * CW;
   localparam int REC_W   = 2 * SUM_W + COUNT_W + 2 * OUT_W;

   bic_cfg_type      cfg_ff, cfg_in;
   logic             csr_write;
   logic [1:0]       reg_index;
   bic_qstat_type    qstat;
   logic             push, pop;
   logic [REC_W-1:0] push_data, head_data;

   // Register write
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_TEST_MODE: cfg_in.test_mode       = pwdata[0];
            REG_THRESHOLD: cfg_in.pixel_threshold = pwdata[PIX_W-1:0];
            REG_WIDTH:     cfg_in.frame_width     = pwdata[DIM_W-1:0];
            default:       cfg_in.frame_height    = pwdata[DIM_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.test_mode       <= MODE_NONZERO;
         cfg_ff.pixel_threshold <= THRESHOLD_RESET;
         cfg_ff.frame_width     <= WIDTH_RESET;
         cfg_ff.frame_height    <= HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read
   always_comb begin
      unique case (reg_index)
         REG_TEST_MODE: prdata = DATA_W'(cfg_ff.test_mode);
         REG_THRESHOLD: prdata = DATA_W'(cfg_ff.pixel_threshold);
         REG_WIDTH:     prdata = DATA_W'(cfg_ff.frame_width);
         default:       prdata = DATA_W'(cfg_ff.frame_height);
      endcase
   end

   bic_front #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_value(req_pixel_value),
      .qstat          (qstat),
      .push           (push),
      .push_data      (push_data)
   );

   bic_queue #(
      .WIDTH(REC_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .status   (qstat)
   );

   bic_back #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_centroid_x (rsp_centroid_x),
      .rsp_centroid_y (rsp_centroid_y),
      .rsp_frame_empty(rsp_frame_empty)
   );

endmodule

`default_nettype wire

FILE: rtl/bic_checker.sv
// Port-level checks of the binary image centroid block and their binding.
`default_nettype none

module bic_checker
   import bic_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [OUT_W-1:0] rsp_centroid_x,
   input wire logic [OUT_W-1:0] rsp_centroid_y,
   input wire logic             rsp_frame_empty,
   input wire logic             pready
);

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_centroid_x)
         && $stable(rsp_centroid_y) && $stable(rsp_frame_empty))
      else $error("stalled response changed");

   // No response right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The queue is empty after reset, so requests are taken
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side stalled after reset");

   // Register port never inserts wait states
   a_pready: assert property (@(posedge clock)
      pready)
      else $error("register port not ready");

endmodule

bind binary_image_centroid bic_checker u_bic_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_centroid_x (rsp_centroid_x),
   .rsp_centroid_y (rsp_centroid_y),
   .rsp_frame_empty(rsp_frame_empty),
   .pready         (pready)
);

`default_nettype wire
